// ----- hw/rtl/bls_pkg.sv -----
// shared types and constants of the bresenham line stepper
`default_nettype none

package bls_pkg;

   localparam int COORD_W         = 13;
   localparam int ERR_W           = 15;
   localparam int CFG_W           = 12;
   localparam int COLOR_W         = 32;
   localparam int PX_W            = 11;
   localparam int PY_W            = 12;
   localparam int CSR_ADDR_W      = 1;
   localparam int REQ_DATA_W      = 88;
   localparam int RSP_DATA_W      = 56;
   localparam int DEFAULT_MAX_DIM = 2048;

   // remainder pipeline: one input stage plus one stage per dividend bit
   localparam int WRAP_LAT        = COORD_W + 1;

   localparam logic [CFG_W-1:0] RESET_WIDTH  = 12'd640;
   localparam logic [CFG_W-1:0] RESET_HEIGHT = 12'd480;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_SCREEN_WIDTH  = 1'b0,
      CSR_SCREEN_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic {
      OP_START = 1'b0,
      OP_STEP  = 1'b1
   } op_type;

   typedef struct packed {
      logic               pixel_valid;
      logic               last_pixel;
      logic [COLOR_W-1:0] color;
   } pix_side_type;

endpackage

`default_nettype wire

// ----- hw/rtl/bresenham_line_stepper.sv -----
// Bresenham line stepper: a start word loads both endpoints and a color and yields the first
// pixel, each step word yields the next pixel, and the end point comes out with tlast set.
// x and y wrap modulo the screen width and height as they stand when the word is accepted
// (a size of zero counts as one, a size above MAX_DIM as MAX_DIM), and the reported y is
// the height minus the wrapped y. One word is accepted per clock and one result word leaves
// per clock while the output is not stalled; each pixel passes through the 14-stage
// remainder pipeline that wraps the coordinates and then the output register. A step after
// the line has ended returns a word with tuser low and all other fields zero.
`default_nettype none

module bresenham_line_stepper
   import bls_pkg::*;
#(
   parameter int MAX_DIM = DEFAULT_MAX_DIM
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_we,
   input  wire logic [CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [CFG_W-1:0]        csr_wdata,
   input  wire logic                    req_tvalid,
   output      logic                    req_tready,
   // start_x, end_x, start_y, end_y, pixel_color, zero pad
   input  wire logic [REQ_DATA_W-1:0]   req_tdata,
   // op
   input  wire logic                    req_tuser,
   output      logic                    rsp_tvalid,
   input  wire logic                    rsp_tready,
   // pixel_x, pixel_y, drawn, color_out
   output      logic [RSP_DATA_W-1:0]   rsp_tdata,
   // pixel_valid
   output      logic                    rsp_tuser,
   output      logic                    rsp_tlast
);

   localparam int DIM_W = $clog2(MAX_DIM + 1);

   logic        [CFG_W-1:0]   screen_width_ff, screen_width_in;
   logic        [CFG_W-1:0]   screen_height_ff, screen_height_in;
   logic        [DIM_W-1:0]   width_eff, height_eff;

   logic signed [COORD_W-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [COORD_W-1:0] tgt_x_ff, tgt_x_in, tgt_y_ff, tgt_y_in;
   logic        [COORD_W-1:0] adx_ff, adx_in;
   logic signed [COORD_W:0]   ndy_ff, ndy_in;
   logic                      dir_x_neg_ff, dir_x_neg_in, dir_y_neg_ff, dir_y_neg_in;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic        [COLOR_W-1:0] color_ff, color_in;
   logic                      active_ff, active_in;

   logic                      adv, accept;
   op_type                    op;
   logic signed [COORD_W-1:0] start_x, end_x, start_y, end_y;
   logic        [COLOR_W-1:0] pixel_color;
   logic                      emit_pix, emit_last;

   logic                      stg_valid_ff [WRAP_LAT];
   pix_side_type              side_ff [WRAP_LAT];
   pix_side_type              side_in;
   logic        [DIM_W-1:0]   hgt_ff [WRAP_LAT];

   logic        [DIM_W-1:0]   rem_x, rem_y;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_pv_ff, rsp_pv_in, rsp_last_ff, rsp_last_in;
   logic                      rsp_drawn_ff, rsp_drawn_in;
   logic        [PX_W-1:0]    rsp_x_ff, rsp_x_in;
   logic        [PY_W-1:0]    rsp_y_ff, rsp_y_in;
   logic        [COLOR_W-1:0] rsp_color_ff, rsp_color_in;

   // register writes
   always_comb begin
      screen_width_in  = screen_width_ff;
      screen_height_in = screen_height_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_SCREEN_WIDTH:  screen_width_in  = csr_wdata;
            CSR_SCREEN_HEIGHT: screen_height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (int'(screen_width_ff) == 0) begin
         width_eff = DIM_W'(1);
      end else if (int'(screen_width_ff) > MAX_DIM) begin
         width_eff = DIM_W'(MAX_DIM);
      end else begin
         width_eff = DIM_W'(screen_width_ff);
      end
      if (int'(screen_height_ff) == 0) begin
         height_eff = DIM_W'(1);
      end else if (int'(screen_height_ff) > MAX_DIM) begin
         height_eff = DIM_W'(MAX_DIM);
      end else begin
         height_eff = DIM_W'(screen_height_ff);
      end
   end

   // whole pipe moves together; it stops only while a result waits
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign accept     = req_tvalid && adv;

   assign op          = op_type'(req_tuser);
   assign start_x     = signed'(req_tdata[12:0]);
   assign end_x       = signed'(req_tdata[25:13]);
   assign start_y     = signed'(req_tdata[38:26]);
   assign end_y       = signed'(req_tdata[51:39]);
   assign pixel_color = req_tdata[83:52];

   // line setup and one bresenham step
   always_comb begin
      logic signed [COORD_W:0] dx, dy;
      logic signed [ERR_W:0]   e2;
      logic signed [ERR_W-1:0] adx_ext, ndy_ext;
      logic                    step_x, step_y;

      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      tgt_x_in     = tgt_x_ff;
      tgt_y_in     = tgt_y_ff;
      adx_in       = adx_ff;
      ndy_in       = ndy_ff;
      dir_x_neg_in = dir_x_neg_ff;
      dir_y_neg_in = dir_y_neg_ff;
      err_in       = err_ff;
      color_in     = color_ff;
      emit_pix     = 1'b0;

      dx      = (COORD_W + 1)'(end_x) - (COORD_W + 1)'(start_x);
      dy      = (COORD_W + 1)'(end_y) - (COORD_W + 1)'(start_y);
      e2      = {err_ff, 1'b0};
      adx_ext = signed'({2'b00, adx_ff});
      ndy_ext = ERR_W'(ndy_ff);
      step_x  = (e2 >= (ERR_W + 1)'(ndy_ff));
      step_y  = (e2 <= (ERR_W + 1)'(adx_ext));

      if (accept) begin
         case (op)
            OP_START: begin
               cur_x_in     = start_x;
               cur_y_in     = start_y;
               tgt_x_in     = end_x;
               tgt_y_in     = end_y;
               adx_in       = dx[COORD_W] ? COORD_W'(-dx) : COORD_W'(dx);
               ndy_in       = dy[COORD_W] ? dy : -dy;
               dir_x_neg_in = !(start_x < end_x);
               dir_y_neg_in = !(start_y < end_y);
               err_in       = signed'({2'b00, adx_in}) + ERR_W'(ndy_in);
               color_in     = pixel_color;
               emit_pix     = 1'b1;
            end
            OP_STEP: begin
               if (active_ff) begin
                  if (step_x) begin
                     cur_x_in = dir_x_neg_ff ? cur_x_ff - 13'sd1 : cur_x_ff + 13'sd1;
                  end
                  if (step_y) begin
                     cur_y_in = dir_y_neg_ff ? cur_y_ff - 13'sd1 : cur_y_ff + 13'sd1;
                  end
                  err_in   = err_ff + (step_x ? ndy_ext : '0) + (step_y ? adx_ext : '0);
                  emit_pix = 1'b1;
               end
            end
            default: ;
         endcase
      end

      emit_last = (cur_x_in == tgt_x_in) && (cur_y_in == tgt_y_in);
      active_in = emit_pix ? !emit_last : active_ff;

      side_in.pixel_valid = emit_pix;
      side_in.last_pixel  = emit_pix && emit_last;
      side_in.color       = color_in;
   end

   bls_wrap #(
      .DIM_W (DIM_W)
   ) u_wrap_x (
      .clock    (clock),
      .en       (adv),
      .value_in (cur_x_in),
      .mod_in   (width_eff),
      .rem_out  (rem_x)
   );

   bls_wrap #(
      .DIM_W (DIM_W)
   ) u_wrap_y (
      .clock    (clock),
      .en       (adv),
      .value_in (cur_y_in),
      .mod_in   (height_eff),
      .rem_out  (rem_y)
   );

   // flip and final result; a word without a pixel is all zeros
   always_comb begin
      logic [DIM_W-1:0] flip_y;
      pix_side_type     side_out;

      side_out     = side_ff[WRAP_LAT-1];
      flip_y       = hgt_ff[WRAP_LAT-1] - rem_y;
      rsp_valid_in = rsp_valid_ff;
      rsp_pv_in    = rsp_pv_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_drawn_in = rsp_drawn_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_color_in = rsp_color_ff;
      if (adv) begin
         rsp_valid_in = stg_valid_ff[WRAP_LAT-1];
         rsp_pv_in    = side_out.pixel_valid;
         rsp_last_in  = side_out.last_pixel;
         if (side_out.pixel_valid) begin
            rsp_drawn_in = (rem_y != '0);
            rsp_x_in     = PX_W'(rem_x);
            rsp_y_in     = PY_W'(flip_y);
            rsp_color_in = side_out.color;
         end else begin
            rsp_drawn_in = 1'b0;
            rsp_x_in     = '0;
            rsp_y_in     = '0;
            rsp_color_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= RESET_WIDTH;
         screen_height_ff <= RESET_HEIGHT;
         cur_x_ff         <= '0;
         cur_y_ff         <= '0;
         tgt_x_ff         <= '0;
         tgt_y_ff         <= '0;
         adx_ff           <= '0;
         ndy_ff           <= '0;
         dir_x_neg_ff     <= 1'b0;
         dir_y_neg_ff     <= 1'b0;
         err_ff           <= '0;
         color_ff         <= '0;
         active_ff        <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         for (int k = 0; k < WRAP_LAT; k++) begin
            stg_valid_ff[k] <= 1'b0;
         end
      end else begin
         screen_width_ff  <= screen_width_in;
         screen_height_ff <= screen_height_in;
         cur_x_ff         <= cur_x_in;
         cur_y_ff         <= cur_y_in;
         tgt_x_ff         <= tgt_x_in;
         tgt_y_ff         <= tgt_y_in;
         adx_ff           <= adx_in;
         ndy_ff           <= ndy_in;
         dir_x_neg_ff     <= dir_x_neg_in;
         dir_y_neg_ff     <= dir_y_neg_in;
         err_ff           <= err_in;
         color_ff         <= color_in;
         active_ff        <= active_in;
         rsp_valid_ff     <= rsp_valid_in;
         if (adv) begin
            stg_valid_ff[0] <= accept;
            for (int k = 1; k < WRAP_LAT; k++) begin
               stg_valid_ff[k] <= stg_valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_in;
         hgt_ff[0]  <= height_eff;
         for (int k = 1; k < WRAP_LAT; k++) begin
            side_ff[k] <= side_ff[k-1];
            hgt_ff[k]  <= hgt_ff[k-1];
         end
      end
      rsp_pv_ff    <= rsp_pv_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_drawn_ff <= rsp_drawn_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_color_ff <= rsp_color_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_pv_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {rsp_color_ff, rsp_drawn_ff, rsp_y_ff, rsp_x_ff};

endmodule

`default_nettype wire

// ----- hw/rtl/bls_wrap.sv -----
// pipelined true-modulo of a signed coordinate by a screen size
`default_nettype none

module bls_wrap
   import bls_pkg::*;
#(
   parameter int DIM_W = 12
) (
   input  wire logic                      clock,
   input  wire logic                      en,
   input  wire logic signed [COORD_W-1:0] value_in,
   input  wire logic        [DIM_W-1:0]   mod_in,
   output      logic        [DIM_W-1:0]   rem_out
);

   logic        [COORD_W-1:0] mag_ff [WRAP_LAT];
   logic                      neg_ff [WRAP_LAT];
   logic        [DIM_W-1:0]   mod_ff [WRAP_LAT];
   logic        [DIM_W-1:0]   rem_ff [WRAP_LAT];
   logic        [DIM_W-1:0]   rem_in [WRAP_LAT];
   logic        [COORD_W-1:0] mag_in;
   logic signed [COORD_W:0]   value_wide;

   always_comb begin
      value_wide = (COORD_W + 1)'(value_in);
      mag_in     = value_in[COORD_W-1] ? COORD_W'(-value_wide) : COORD_W'(value_wide);
   end

   // restoring remainder, one dividend bit per stage, msb first
   always_comb begin
      logic [DIM_W:0] trial;
      rem_in[0] = '0;
      for (int k = 1; k < WRAP_LAT; k++) begin
         trial = {rem_ff[k-1], mag_ff[k-1][COORD_W-k]};
         if (trial >= {1'b0, mod_ff[k-1]}) begin
            rem_in[k] = DIM_W'(trial - {1'b0, mod_ff[k-1]});
         end else begin
            rem_in[k] = DIM_W'(trial);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff[0] <= mag_in;
         neg_ff[0] <= value_in[COORD_W-1];
         mod_ff[0] <= mod_in;
         rem_ff[0] <= rem_in[0];
         for (int k = 1; k < WRAP_LAT; k++) begin
            mag_ff[k] <= mag_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
            mod_ff[k] <= mod_ff[k-1];
            rem_ff[k] <= rem_in[k];
         end
      end
   end

   // negative value with nonzero remainder folds back into range
   always_comb begin
      if (neg_ff[WRAP_LAT-1] && (rem_ff[WRAP_LAT-1] != '0)) begin
         rem_out = mod_ff[WRAP_LAT-1] - rem_ff[WRAP_LAT-1];
      end else begin
         rem_out = rem_ff[WRAP_LAT-1];
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/bls_checker.sv -----
// port-level checks of the bresenham line stepper, bound to the top level
`default_nettype none

module bls_checker
   import bls_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tuser,
   input wire logic                  rsp_tlast
);

   // stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result word changed");

   // input side only stops while a result waits
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   // word without a pixel carries only zeros
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> (rsp_tdata == '0) && !rsp_tlast)
      else $error("idle step word not zero");

   // flipped y is never zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[22:11] != '0)
      else $error("pixel y out of range");

   // output empties on reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind bresenham_line_stepper bls_checker u_bls_checker (.*);

`default_nettype wire
